// File: rtl/sfpalu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sfpalu_pkg
// Shared constants, operation codes and types of the saturating Q-format ALU.
// ---------------------------------------------------------------------------
package sfpalu_pkg;

    localparam int SFPALU_DATA_WIDTH  = 16;
    localparam int SFPALU_FRAC_BITS   = 8;
    localparam int SFPALU_QUEUE_DEPTH = 2;

    // Operation codes on the request channel
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // Work class decided by the front end
    localparam int KIND_W = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD,
        KIND_SUB,
        KIND_MUL,
        KIND_DIV,
        KIND_DIVZ
    } kind_t;

    // Execution unit sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_RND,
        ST_DIV_PREP,
        ST_DIV,
        ST_DIV_FIX,
        ST_EMIT
    } st_t;

endpackage
`default_nettype wire

// File: rtl/sfpalu_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sfpalu_req_if
// Request channel: operation, two Q-format operands and the sticky clear.
// ---------------------------------------------------------------------------
interface sfpalu_req_if
    import sfpalu_pkg::*;
#(
    parameter int DATA_WIDTH = SFPALU_DATA_WIDTH
) ();

    logic                         valid;
    logic                         ready;
    logic [1:0]                   req_type;
    logic signed [DATA_WIDTH-1:0] operand_a;
    logic signed [DATA_WIDTH-1:0] operand_b;
    logic                         clear_sticky;

    modport source (
        output valid, req_type, operand_a, operand_b, clear_sticky,
        input  ready
    );

    modport sink (
        input  valid, req_type, operand_a, operand_b, clear_sticky,
        output ready
    );

endinterface
`default_nettype wire

// File: rtl/sfpalu_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sfpalu_rsp_if
// Result channel: saturated value, per-operation flag and sticky flag.
// ---------------------------------------------------------------------------
interface sfpalu_rsp_if
    import sfpalu_pkg::*;
#(
    parameter int DATA_WIDTH = SFPALU_DATA_WIDTH
) ();

    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] result_value;
    logic                         saturated;
    logic                         limit_sticky;

    modport source (
        output valid, result_value, saturated, limit_sticky,
        input  ready
    );

    modport sink (
        input  valid, result_value, saturated, limit_sticky,
        output ready
    );

endinterface
`default_nettype wire

// File: rtl/saturating_fixed_point_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// saturating_fixed_point_alu
// Signed Q-format ALU (add, subtract, rounded multiply, divide) with
// saturation, a per-result limit flag and a sticky limit flag.
// ---------------------------------------------------------------------------
// Usage:
//   req : one transfer per operation (req_type, operand_a, operand_b,
//         clear_sticky); rsp : one transfer per result (result_value,
//         saturated, limit_sticky), in request order.
//   A front end registers and classifies each request, a short queue holds
//   it, and the execution unit works on one item at a time.
//   A request passes the front end register and the queue into the
//   execution unit; add, subtract and divide by zero go from ST_IDLE to
//   ST_EMIT, a multiply through ST_MUL (multiply) and ST_RND (round), a
//   divide through ST_DIV_PREP, the ST_DIV loop and ST_DIV_FIX, and ST_EMIT
//   clamps and fills the result register that drives rsp.valid. Throughput
//   is set by the execution unit, which takes the next item only in ST_IDLE;
//   the restoring divider makes one quotient bit per cycle.
//   Reset clears the sticky flag, empties the queue and drops any result not
//   yet transferred. When rsp is stalled the result register holds, the
//   execution unit waits, and the front end keeps taking requests until the
//   queue and its own register are full.
// ---------------------------------------------------------------------------
module saturating_fixed_point_alu
    import sfpalu_pkg::*;
#(
    parameter int DATA_WIDTH  = SFPALU_DATA_WIDTH,
    parameter int FRAC_BITS   = SFPALU_FRAC_BITS,
    parameter int QUEUE_DEPTH = SFPALU_QUEUE_DEPTH
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    sfpalu_req_if.sink   req,
    sfpalu_rsp_if.source rsp
);

    localparam int CMD_W = KIND_W + 1 + 2 * DATA_WIDTH;

    logic             fr_valid;
    logic             fr_ready;
    logic [CMD_W-1:0] fr_data;
    logic             ex_valid;
    logic             ex_ready;
    logic [CMD_W-1:0] ex_data;

    // Accept and classify requests
    sfpalu_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (fr_valid),
        .cmd_ready (fr_ready),
        .cmd_data  (fr_data)
    );

    // Decouple the front end from the execution unit
    sfpalu_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_data  (fr_data),
        .pop_valid  (ex_valid),
        .pop_ready  (ex_ready),
        .pop_data   (ex_data)
    );

    // Execute, saturate and hold the result for transfer
    sfpalu_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (ex_valid),
        .cmd_ready (ex_ready),
        .cmd_data  (ex_data),
        .rsp       (rsp)
    );

endmodule
`default_nettype wire

// File: rtl/sfpalu_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sfpalu_front
// Accept requests, classify them (divide by zero split off) and register.
// ---------------------------------------------------------------------------
module sfpalu_front
    import sfpalu_pkg::*;
#(
    parameter int  DATA_WIDTH = SFPALU_DATA_WIDTH,
    localparam int CMD_W      = KIND_W + 1 + 2 * DATA_WIDTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    sfpalu_req_if.sink            req,
    output logic                  cmd_valid,
    input  wire logic             cmd_ready,
    output logic [CMD_W-1:0]      cmd_data
);

    typedef struct packed {
        kind_t                        kind;
        logic                         clr;
        logic signed [DATA_WIDTH-1:0] a;
        logic signed [DATA_WIDTH-1:0] b;
    } cmd_t;

    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic valid_reg;
    logic valid_next;
    logic take;

    assign req.ready = !valid_reg || cmd_ready;
    assign take      = req.valid && req.ready;

    always_comb
    begin
        cmd_next.clr = req.clear_sticky;
        cmd_next.a   = req.operand_a;
        cmd_next.b   = req.operand_b;
        unique case (req.req_type)
            OP_ADD: cmd_next.kind = KIND_ADD;
            OP_SUB: cmd_next.kind = KIND_SUB;
            OP_MUL: cmd_next.kind = KIND_MUL;
            OP_DIV: cmd_next.kind = (req.operand_b == '0) ? KIND_DIVZ : KIND_DIV;
        endcase
    end

    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else if (cmd_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            cmd_reg <= cmd_next;
    end

    assign cmd_valid = valid_reg;
    assign cmd_data  = cmd_reg;

endmodule
`default_nettype wire

// File: rtl/sfpalu_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sfpalu_queue
// Short first-in first-out queue between the front end and the execution unit.
// ---------------------------------------------------------------------------
module sfpalu_queue
    import sfpalu_pkg::*;
#(
    parameter int  WIDTH = 1,
    parameter int  DEPTH = SFPALU_QUEUE_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule
`default_nettype wire

// File: rtl/sfpalu_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sfpalu_back
// Execution unit: add/subtract, multiply with rounding, restoring divide,
// saturation, sticky flag and the result register.
// ---------------------------------------------------------------------------
module sfpalu_back
    import sfpalu_pkg::*;
#(
    parameter int  DATA_WIDTH = SFPALU_DATA_WIDTH,
    parameter int  FRAC_BITS  = SFPALU_FRAC_BITS,
    localparam int CMD_W      = KIND_W + 1 + 2 * DATA_WIDTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    output logic                  cmd_ready,
    input  wire logic [CMD_W-1:0] cmd_data,
    sfpalu_rsp_if.source          rsp
);

    // Raw width holds products and divide numerators without wrap
    localparam int RAW_W = (2 * DATA_WIDTH > DATA_WIDTH + FRAC_BITS + 2)
                         ? 2 * DATA_WIDTH : DATA_WIDTH + FRAC_BITS + 2;
    localparam int NB    = DATA_WIDTH + FRAC_BITS + 1;   // quotient bits
    localparam int CNT_W = $clog2(NB);
    localparam int DVS_W = DATA_WIDTH + 1;

    localparam logic signed [RAW_W-1:0] SAT_MAX_R =
        {{(RAW_W - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic signed [RAW_W-1:0] SAT_MIN_R =
        {{(RAW_W - DATA_WIDTH + 1){1'b1}}, {(DATA_WIDTH - 1){1'b0}}};
    localparam logic signed [RAW_W-1:0] HALF_R = RAW_W'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        kind_t                        kind;
        logic                         clr;
        logic signed [DATA_WIDTH-1:0] a;
        logic signed [DATA_WIDTH-1:0] b;
    } cmd_t;

    cmd_t cmd;
    st_t  state_reg;
    st_t  state_next;

    logic signed [DATA_WIDTH-1:0]   a_reg;
    logic signed [DATA_WIDTH-1:0]   b_reg;
    logic signed [RAW_W-1:0]        raw_reg;
    logic [DVS_W-1:0]               rem_reg;
    logic [DVS_W-1:0]               dvs_reg;
    logic [NB-1:0]                  quo_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic                           neg_reg;
    logic                           clr_reg;
    logic                           sticky_reg;
    logic                           sticky_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic signed [DATA_WIDTH-1:0]   out_value_reg;
    logic                           out_sat_reg;
    logic                           out_sticky_reg;

    logic signed [2*DATA_WIDTH-1:0] prod;
    logic signed [RAW_W-1:0]        raw_abs;
    logic signed [DVS_W-1:0]        b_ext;
    logic [DVS_W-1:0]               b_abs;
    logic [DVS_W-1:0]               shifted;
    logic [DVS_W:0]                 diff;
    logic signed [RAW_W-1:0]        q_ext;
    logic                           a_pos;
    logic                           ge_max;
    logic                           le_min;
    logic                           sat_hit;
    logic signed [DATA_WIDTH-1:0]   sat_value;
    logic                           out_free;
    logic                           emit;

    assign cmd = cmd_data;

    // Datapath helpers
    assign prod    = a_reg * b_reg;
    assign raw_abs = raw_reg[RAW_W-1] ? -raw_reg : raw_reg;
    assign b_ext   = DVS_W'(b_reg);
    assign b_abs   = b_reg[DATA_WIDTH-1] ? DVS_W'(-b_ext) : DVS_W'(b_ext);
    assign shifted = {rem_reg[DVS_W-2:0], quo_reg[NB-1]};
    assign diff    = {1'b0, shifted} - {1'b0, dvs_reg};
    assign q_ext   = signed'(RAW_W'(quo_reg));
    assign a_pos   = !cmd.a[DATA_WIDTH-1] && (cmd.a != '0);

    // Clamp; reaching an extreme exactly also counts
    assign ge_max    = (raw_reg >= SAT_MAX_R);
    assign le_min    = (raw_reg <= SAT_MIN_R);
    assign sat_hit   = ge_max || le_min;
    assign sat_value = ge_max ? SAT_MAX_R[DATA_WIDTH-1:0]
                     : le_min ? SAT_MIN_R[DATA_WIDTH-1:0]
                     : raw_reg[DATA_WIDTH-1:0];

    assign out_free = !out_valid_reg || rsp.ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.kind)
                        KIND_MUL: state_next = ST_MUL;
                        KIND_DIV: state_next = ST_DIV_PREP;
                        default:  state_next = ST_EMIT;
                    endcase
                end
            end
            ST_MUL:      state_next = ST_RND;
            ST_RND:      state_next = ST_EMIT;
            ST_DIV_PREP: state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(NB - 1))
                    state_next = ST_DIV_FIX;
            end
            ST_DIV_FIX:  state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        cmd_ready = 1'b0;
        emit      = 1'b0;
        unique case (state_reg)
            ST_IDLE: cmd_ready = 1'b1;
            ST_EMIT: emit      = out_free;
            default: ;
        endcase
    end

    always_comb
    begin
        sticky_next    = sticky_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            sticky_next    = clr_reg ? 1'b0 : (sticky_reg || sat_hit);
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sticky_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sticky_reg    <= sticky_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    clr_reg <= cmd.clr;
                    a_reg   <= cmd.a;
                    b_reg   <= cmd.b;
                    unique case (cmd.kind)
                        KIND_ADD:  raw_reg <= RAW_W'(cmd.a) + RAW_W'(cmd.b);
                        KIND_SUB:  raw_reg <= RAW_W'(cmd.a) - RAW_W'(cmd.b);
                        KIND_DIV:  raw_reg <= (RAW_W'(cmd.a) <<< FRAC_BITS)
                                            + (RAW_W'(cmd.b) >>> 1);
                        KIND_DIVZ: raw_reg <= a_pos ? SAT_MAX_R : SAT_MIN_R;
                        default:   raw_reg <= raw_reg;
                    endcase
                end
            end
            ST_MUL:
                raw_reg <= RAW_W'(prod);
            ST_RND:
                raw_reg <= (raw_reg + HALF_R) >>> FRAC_BITS;
            ST_DIV_PREP:
            begin
                neg_reg <= raw_reg[RAW_W-1] ^ b_reg[DATA_WIDTH-1];
                quo_reg <= raw_abs[NB-1:0];
                dvs_reg <= b_abs;
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            ST_DIV:
            begin
                if (!diff[DVS_W])
                begin
                    rem_reg <= diff[DVS_W-1:0];
                    quo_reg <= {quo_reg[NB-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= shifted;
                    quo_reg <= {quo_reg[NB-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
            ST_DIV_FIX:
                raw_reg <= neg_reg ? -q_ext : q_ext;
            ST_EMIT:
            begin
                if (emit)
                begin
                    out_value_reg  <= sat_value;
                    out_sat_reg    <= sat_hit;
                    out_sticky_reg <= sticky_reg || sat_hit;
                end
            end
            default: ;
        endcase
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = out_value_reg;
    assign rsp.saturated    = out_sat_reg;
    assign rsp.limit_sticky = out_sticky_reg;

`ifndef SYNTH
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < dvs_reg))
        else $error("partial remainder not below divisor");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (dvs_reg != '0))
        else $error("zero divisor reached the divide loop");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg < CNT_W'(NB)))
        else $error("divide step counter overran");

    a_sticky_cover: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_sat_reg) |-> out_sticky_reg)
        else $error("saturated result reported without sticky flag");
`endif

endmodule
`default_nettype wire
